// ===== hdl/slx_pkg.sv =====
`timescale 1ns / 1ps
package slx_pkg;

  // Result event kinds
  localparam logic [1:0] EV_BYTE = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;

  // Token types
  localparam logic [3:0] TT_LPAR = 4'd0;
  localparam logic [3:0] TT_RPAR = 4'd1;
  localparam logic [3:0] TT_BIN  = 4'd2;
  localparam logic [3:0] TT_HEX  = 4'd3;
  localparam logic [3:0] TT_DEC  = 4'd4;
  localparam logic [3:0] TT_STR  = 4'd5;
  localparam logic [3:0] TT_SYM  = 4'd6;
  localparam logic [3:0] TT_KW   = 4'd7;
  localparam logic [3:0] TT_US   = 4'd8;

  // Lexical error codes
  localparam logic [3:0] ERR_ILLEGAL    = 4'd0;
  localparam logic [3:0] ERR_AFTER_HASH = 4'd1;
  localparam logic [3:0] ERR_BIN_DIGIT  = 4'd2;
  localparam logic [3:0] ERR_HEX_DIGIT  = 4'd3;
  localparam logic [3:0] ERR_STR_CHAR   = 4'd4;
  localparam logic [3:0] ERR_ESCAPE     = 4'd5;
  localparam logic [3:0] ERR_QUOTED     = 4'd6;
  localparam logic [3:0] ERR_AFTER_COLON = 4'd7;
  localparam logic [3:0] ERR_FRAC_DIGIT = 4'd8;
  localparam logic [3:0] ERR_UNFINISHED = 4'd9;

  // Character codes with a role of their own
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_BAR    = 8'h7C;

  // One result of the lexer
  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] dat;
    logic [3:0] ttype;
    logic [3:0] err;
  } res_t;

  // All results caused by one input transaction (cnt is 0 to 3; only batches with cnt 1 to 3 are pushed)
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [2:0]     res;
  } batch_t;

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r = '{ev: EV_BYTE, dat: b, ttype: 4'd0, err: 4'd0};
    return r;
  endfunction

  function automatic res_t mk_end(input logic [3:0] t);
    res_t r;
    r = '{ev: EV_END, dat: 8'd0, ttype: t, err: 4'd0};
    return r;
  endfunction

  function automatic res_t mk_err(input logic [3:0] e);
    res_t r;
    r = '{ev: EV_ERR, dat: 8'd0, ttype: 4'd0, err: e};
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  // Letters, digits and + - / * = % ? ! . $ _ ~ & ^ < > @
  function automatic logic is_sym(input logic [7:0] b);
    logic extra;
    extra = (b == 8'h2B) || (b == 8'h2D) || (b == 8'h2F) || (b == 8'h2A) ||
            (b == 8'h3D) || (b == 8'h25) || (b == 8'h3F) || (b == 8'h21) ||
            (b == CH_DOT) || (b == 8'h24) || (b == CH_USCORE) || (b == 8'h7E) ||
            (b == 8'h26) || (b == 8'h5E) || (b == 8'h3C) || (b == 8'h3E) ||
            (b == 8'h40);
    return is_letter(b) || is_digit(b) || extra;
  endfunction

  // Printable ASCII plus tab, CR and LF
  function automatic logic is_strch(input logic [7:0] b);
    return (b >= 8'h20 && b <= 8'h7E) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_quotch(input logic [7:0] b);
    return is_strch(b) && (b != CH_BSLASH) && (b != CH_BAR);
  endfunction

endpackage

// ===== hdl/slx_front.sv =====
`timescale 1ns / 1ps
module slx_front import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] b,
  input  logic       eoi,
  output logic       push,
  output batch_t     batch
);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_COMMENT    = 5'd1;
  localparam logic [4:0] S_HASH       = 5'd2;
  localparam logic [4:0] S_BIN_FIRST  = 5'd3;
  localparam logic [4:0] S_BIN        = 5'd4;
  localparam logic [4:0] S_HEX_FIRST  = 5'd5;
  localparam logic [4:0] S_HEX        = 5'd6;
  localparam logic [4:0] S_STRING     = 5'd7;
  localparam logic [4:0] S_ESCAPE     = 5'd8;
  localparam logic [4:0] S_QUOTED     = 5'd9;
  localparam logic [4:0] S_COLON      = 5'd10;
  localparam logic [4:0] S_KEYWORD    = 5'd11;
  localparam logic [4:0] S_ZERO       = 5'd12;
  localparam logic [4:0] S_DEC        = 5'd13;
  localparam logic [4:0] S_FRAC_FIRST = 5'd14;
  localparam logic [4:0] S_FRAC       = 5'd15;
  localparam logic [4:0] S_SYMBOL     = 5'd16;
  localparam logic [4:0] S_HALT       = 5'd17;

  logic [4:0] st_r, st_nxt;
  logic       lone_r, lone_nxt;

  // Outcome of handling the byte from idle
  logic [1:0] id_n;
  res_t       id_r0, id_r1;
  logic [4:0] id_st;
  logic       id_lone_we;
  logic       id_lone;

  // Classify the byte as the first byte of a token
  always_comb begin
    id_n       = 2'd0;
    id_r0      = mk_byte(b);
    id_r1      = '0;
    id_st      = S_IDLE;
    id_lone_we = 1'b0;
    id_lone    = 1'b0;
    if (b == CH_SEMI) begin
      id_st = S_COMMENT;
    end else if (is_space(b)) begin
      id_st = S_IDLE;
    end else if (b == CH_LPAR) begin
      id_n  = 2'd2;
      id_r1 = mk_end(TT_LPAR);
    end else if (b == CH_RPAR) begin
      id_n  = 2'd2;
      id_r1 = mk_end(TT_RPAR);
    end else if (b == CH_HASH) begin
      id_n  = 2'd1;
      id_st = S_HASH;
    end else if (b == CH_DQUOTE) begin
      id_n  = 2'd1;
      id_st = S_STRING;
    end else if (b == CH_BAR) begin
      id_n  = 2'd1;
      id_st = S_QUOTED;
    end else if (b == CH_COLON) begin
      id_n  = 2'd1;
      id_st = S_COLON;
    end else if (b == CH_ZERO) begin
      id_n  = 2'd1;
      id_st = S_ZERO;
    end else if (is_digit(b)) begin
      id_n  = 2'd1;
      id_st = S_DEC;
    end else if (is_sym(b)) begin
      id_n       = 2'd1;
      id_st      = S_SYMBOL;
      id_lone_we = 1'b1;
      id_lone    = (b == CH_USCORE);
    end else begin
      id_n  = 2'd1;
      id_r0 = mk_err(ERR_ILLEGAL);
      id_st = S_HALT;
    end
  end

  logic       fin;
  logic [3:0] fin_type;

  // Advance the token state machine
  always_comb begin
    st_nxt    = st_r;
    lone_nxt  = lone_r;
    batch     = '0;
    fin       = 1'b0;
    fin_type  = TT_SYM;
    if (eoi) begin
      st_nxt   = S_IDLE;
      lone_nxt = 1'b0;
      case (st_r)
        S_BIN: begin
          batch.cnt = 2'd1; batch.res[0] = mk_end(TT_BIN);
        end
        S_HEX: begin
          batch.cnt = 2'd1; batch.res[0] = mk_end(TT_HEX);
        end
        S_KEYWORD: begin
          batch.cnt = 2'd1; batch.res[0] = mk_end(TT_KW);
        end
        S_ZERO, S_DEC, S_FRAC: begin
          batch.cnt = 2'd1; batch.res[0] = mk_end(TT_DEC);
        end
        S_SYMBOL: begin
          batch.cnt = 2'd1; batch.res[0] = mk_end(lone_r ? TT_US : TT_SYM);
        end
        S_HASH, S_BIN_FIRST, S_HEX_FIRST, S_STRING, S_ESCAPE, S_QUOTED, S_COLON,
        S_FRAC_FIRST: begin
          batch.cnt = 2'd1; batch.res[0] = mk_err(ERR_UNFINISHED);
        end
        default: begin
          batch.cnt = 2'd0;
        end
      endcase
    end else begin
      case (st_r)
        S_IDLE: begin
          batch.cnt    = id_n;
          batch.res[0] = id_r0;
          batch.res[1] = id_r1;
          st_nxt       = id_st;
          if (id_lone_we) lone_nxt = id_lone;
        end
        S_COMMENT: begin
          if (b == CH_LF) st_nxt = S_IDLE;
        end
        S_HASH: begin
          batch.cnt = 2'd1;
          if (b == CH_LOW_B) begin
            batch.res[0] = mk_byte(b); st_nxt = S_BIN_FIRST;
          end else if (b == CH_LOW_X) begin
            batch.res[0] = mk_byte(b); st_nxt = S_HEX_FIRST;
          end else begin
            batch.res[0] = mk_err(ERR_AFTER_HASH); st_nxt = S_HALT;
          end
        end
        S_BIN_FIRST, S_BIN: begin
          if (b == CH_ZERO || b == CH_ONE) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b); st_nxt = S_BIN;
          end else if (st_r == S_BIN_FIRST) begin
            batch.cnt = 2'd1; batch.res[0] = mk_err(ERR_BIN_DIGIT); st_nxt = S_HALT;
          end else begin
            fin = 1'b1; fin_type = TT_BIN;
          end
        end
        S_HEX_FIRST, S_HEX: begin
          if (is_hex(b)) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b); st_nxt = S_HEX;
          end else if (st_r == S_HEX_FIRST) begin
            batch.cnt = 2'd1; batch.res[0] = mk_err(ERR_HEX_DIGIT); st_nxt = S_HALT;
          end else begin
            fin = 1'b1; fin_type = TT_HEX;
          end
        end
        S_STRING: begin
          if (b == CH_DQUOTE) begin
            batch.cnt = 2'd2; batch.res[0] = mk_byte(b);
            batch.res[1] = mk_end(TT_STR); st_nxt = S_IDLE;
          end else if (b == CH_BSLASH) begin
            st_nxt = S_ESCAPE;
          end else if (is_strch(b)) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b);
          end else begin
            batch.cnt = 2'd1; batch.res[0] = mk_err(ERR_STR_CHAR); st_nxt = S_HALT;
          end
        end
        S_ESCAPE: begin
          batch.cnt = 2'd1;
          if (b == CH_DQUOTE || b == CH_BSLASH) begin
            batch.res[0] = mk_byte(b); st_nxt = S_STRING;
          end else begin
            batch.res[0] = mk_err(ERR_ESCAPE); st_nxt = S_HALT;
          end
        end
        S_QUOTED: begin
          if (b == CH_BAR) begin
            batch.cnt = 2'd2; batch.res[0] = mk_byte(b);
            batch.res[1] = mk_end(TT_SYM); st_nxt = S_IDLE;
          end else if (is_quotch(b)) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b);
          end else begin
            batch.cnt = 2'd1; batch.res[0] = mk_err(ERR_QUOTED); st_nxt = S_HALT;
          end
        end
        S_COLON, S_KEYWORD: begin
          if (is_sym(b)) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b); st_nxt = S_KEYWORD;
          end else if (st_r == S_COLON) begin
            batch.cnt = 2'd1; batch.res[0] = mk_err(ERR_AFTER_COLON); st_nxt = S_HALT;
          end else begin
            fin = 1'b1; fin_type = TT_KW;
          end
        end
        S_ZERO: begin
          if (b == CH_DOT) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b); st_nxt = S_FRAC_FIRST;
          end else begin
            fin = 1'b1; fin_type = TT_DEC;
          end
        end
        S_DEC: begin
          if (is_digit(b)) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b);
          end else if (b == CH_DOT) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b); st_nxt = S_FRAC_FIRST;
          end else begin
            fin = 1'b1; fin_type = TT_DEC;
          end
        end
        S_FRAC_FIRST, S_FRAC: begin
          if (is_digit(b)) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b); st_nxt = S_FRAC;
          end else if (st_r == S_FRAC_FIRST) begin
            batch.cnt = 2'd1; batch.res[0] = mk_err(ERR_FRAC_DIGIT); st_nxt = S_HALT;
          end else begin
            fin = 1'b1; fin_type = TT_DEC;
          end
        end
        S_SYMBOL: begin
          if (is_sym(b)) begin
            batch.cnt = 2'd1; batch.res[0] = mk_byte(b); lone_nxt = 1'b0;
          end else begin
            fin = 1'b1; fin_type = lone_r ? TT_US : TT_SYM;
          end
        end
        default: begin
          // halted: drop bytes until end of input
          st_nxt = st_r;
        end
      endcase

      // End the token, then treat the terminating byte as a token start
      if (fin) begin
        batch.cnt    = id_n + 2'd1;
        batch.res[0] = mk_end(fin_type);
        batch.res[1] = id_r0;
        batch.res[2] = id_r1;
        st_nxt       = id_st;
        if (id_lone_we) lone_nxt = id_lone;
      end
    end
  end

  assign push = acc && (batch.cnt != 2'd0);

  // Hold lexer state, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      lone_r <= 1'b0;
    end else if (acc) begin
      st_r   <= st_nxt;
      lone_r <= lone_nxt;
    end
  end

endmodule

// ===== hdl/slx_queue.sv =====
`timescale 1ns / 1ps
module slx_queue import slx_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  batch_t wr_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output batch_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  batch_t         mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the batch
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== hdl/slx_back.sv =====
`timescale 1ns / 1ps
module slx_back import slx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  batch_t     q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_byte,
  output logic [3:0] out_token_type,
  output logic [3:0] out_error_code,
  output logic       out_last
);

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  res_t       res_r, res_nxt;
  logic       last_r, last_nxt;
  logic       open;
  logic       load;
  logic       is_last;

  assign open    = !vld_r || !out_stall;
  assign load    = open && q_not_empty;
  assign is_last = ((idx_r + 2'd1) == q_head.cnt);
  assign q_pop   = load && is_last;

  // Step through the head batch one result per transaction
  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    res_nxt  = res_r;
    last_nxt = last_r;
    if (open) begin
      vld_nxt = q_not_empty;
    end
    if (load) begin
      res_nxt  = q_head.res[idx_r];
      last_nxt = is_last;
      idx_nxt  = is_last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  // Hold output payload while stalled
  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = vld_r;
  assign out_event_res  = res_r.ev;
  assign out_byte       = res_r.dat;
  assign out_token_type = res_r.ttype;
  assign out_error_code = res_r.err;
  assign out_last       = last_r;

endmodule

// ===== hdl/smtlib2_token_lexer_unit.sv =====
`timescale 1ns / 1ps
// Path: the results of an input transaction pass through the batch queue, then the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and the
// output is not stalled; a byte yielding up to three results holds the single output register
// for one result at a time, and the batch queue (QUEUE_DEPTH entries) absorbs the difference.
// Reset: synchronous, active low; lexer returns to idle, queue and output empty.
module smtlib2_token_lexer_unit import slx_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_event_res,
  output logic [7:0] out_byte,
  output logic [3:0] out_token_type,
  output logic [3:0] out_error_code,
  output logic       out_last
);

  logic   acc;
  logic   push;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;
  batch_t wr_batch;
  batch_t head_batch;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // Classify bytes and build result batches
  slx_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .b     (in_byte),
    .eoi   (in_end_of_input),
    .push  (push),
    .batch (wr_batch)
  );

  // Decouple front and back
  slx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (wr_batch),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (head_batch)
  );

  // Serialize results onto the output channel
  slx_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_not_empty    (q_not_empty),
    .q_head         (head_batch),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_res  (out_event_res),
    .out_byte       (out_byte),
    .out_token_type (out_token_type),
    .out_error_code (out_error_code),
    .out_last       (out_last)
  );

endmodule

// ===== test/smtlib2_token_lexer_unit_tb.sv =====
`timescale 1ns / 1ps
module smtlib2_token_lexer_unit_tb;
  import slx_pkg::*;

  localparam int ITEM_GOAL = 350;
  localparam string DIGITS = "0123456789";
  localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
  localparam string SYM_EXTRA = "+-/*=%?!.$_~&^<>@";
  localparam string SYM_START =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+-/*=%?!.$_~&^<>@";
  localparam string SYM_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-/*=%?!.$_~&^<>@";

  typedef enum logic [4:0] {
    LX_IDLE, LX_COMMENT, LX_HASH, LX_BIN_FIRST, LX_BIN, LX_HEX_FIRST, LX_HEX,
    LX_STRING, LX_ESCAPE, LX_QUOTED, LX_COLON, LX_KEYWORD, LX_ZERO, LX_DEC,
    LX_FRAC_FIRST, LX_FRAC, LX_SYMBOL, LX_HALT
  } lex_state_t;

  typedef struct {
    res_t r;
    logic last;
  } lex_event_t;

  class lexer_scoreboard;
    lex_state_t st = LX_IDLE;
    logic lone_us = 1'b0;
    res_t step_res[$];
    lex_event_t pending_events[$];
    int failures = 0;

    function bit in_list(string s, logic [7:0] b);
      for (int i = 0; i < s.len(); i++)
        if (s[i] == b) return 1'b1;
      return 1'b0;
    endfunction

    function bit num_ch(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function bit blank_ch(logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function bit sym_ch(logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || num_ch(b) ||
             in_list(SYM_EXTRA, b);
    endfunction

    function bit text_ch(logic [7:0] b);
      return (b >= 8'h20 && b <= 8'h7E) || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function void add(logic [1:0] ev, logic [7:0] d, logic [3:0] t, logic [3:0] e);
      res_t r;
      r.ev = ev;
      r.dat = d;
      r.ttype = t;
      r.err = e;
      if (step_res.size() < 3) step_res = {step_res, r};
    endfunction

    function void tok_byte(logic [7:0] b);
      add(EV_BYTE, b, '0, '0);
    endfunction

    function void tok_end(logic [3:0] t);
      add(EV_END, '0, t, '0);
      st = LX_IDLE;
    endfunction

    function void tok_err(logic [3:0] e);
      add(EV_ERR, '0, '0, e);
      st = LX_HALT;
    endfunction

    // Open a new token from idle
    function void begin_token(logic [7:0] b);
      if (b == CH_SEMI) st = LX_COMMENT;
      else if (blank_ch(b)) begin
      end else if (b == CH_LPAR) begin
        tok_byte(b);
        tok_end(TT_LPAR);
      end else if (b == CH_RPAR) begin
        tok_byte(b);
        tok_end(TT_RPAR);
      end else if (b == CH_HASH) begin
        tok_byte(b);
        st = LX_HASH;
      end else if (b == CH_DQUOTE) begin
        tok_byte(b);
        st = LX_STRING;
      end else if (b == CH_BAR) begin
        tok_byte(b);
        st = LX_QUOTED;
      end else if (b == CH_COLON) begin
        tok_byte(b);
        st = LX_COLON;
      end else if (b == CH_ZERO) begin
        tok_byte(b);
        st = LX_ZERO;
      end else if (num_ch(b)) begin
        tok_byte(b);
        st = LX_DEC;
      end else if (sym_ch(b)) begin
        tok_byte(b);
        lone_us = (b == CH_USCORE);
        st = LX_SYMBOL;
      end else tok_err(ERR_ILLEGAL);
    endfunction

    // Close the token, then handle the terminator from idle
    function void close_token(logic [3:0] t, logic [7:0] b);
      tok_end(t);
      begin_token(b);
    endfunction

    function void lex_byte(logic [7:0] b);
      case (st)
        LX_IDLE: begin_token(b);
        LX_COMMENT: if (b == CH_LF) st = LX_IDLE;
        LX_HASH: begin
          if (b == CH_LOW_B) begin
            tok_byte(b);
            st = LX_BIN_FIRST;
          end else if (b == CH_LOW_X) begin
            tok_byte(b);
            st = LX_HEX_FIRST;
          end else tok_err(ERR_AFTER_HASH);
        end
        LX_BIN_FIRST, LX_BIN: begin
          if (b == CH_ZERO || b == CH_ONE) begin
            tok_byte(b);
            st = LX_BIN;
          end else if (st == LX_BIN_FIRST) tok_err(ERR_BIN_DIGIT);
          else close_token(TT_BIN, b);
        end
        LX_HEX_FIRST, LX_HEX: begin
          if (in_list(HEX_DIGITS, b)) begin
            tok_byte(b);
            st = LX_HEX;
          end else if (st == LX_HEX_FIRST) tok_err(ERR_HEX_DIGIT);
          else close_token(TT_HEX, b);
        end
        LX_STRING: begin
          if (b == CH_DQUOTE) begin
            tok_byte(b);
            tok_end(TT_STR);
          end else if (b == CH_BSLASH) st = LX_ESCAPE;
          else if (text_ch(b)) tok_byte(b);
          else tok_err(ERR_STR_CHAR);
        end
        LX_ESCAPE: begin
          if (b == CH_DQUOTE || b == CH_BSLASH) begin
            tok_byte(b);
            st = LX_STRING;
          end else tok_err(ERR_ESCAPE);
        end
        LX_QUOTED: begin
          if (b == CH_BAR) begin
            tok_byte(b);
            tok_end(TT_SYM);
          end else if (text_ch(b) && b != CH_BSLASH) tok_byte(b);
          else tok_err(ERR_QUOTED);
        end
        LX_COLON, LX_KEYWORD: begin
          if (sym_ch(b)) begin
            tok_byte(b);
            st = LX_KEYWORD;
          end else if (st == LX_COLON) tok_err(ERR_AFTER_COLON);
          else close_token(TT_KW, b);
        end
        LX_ZERO: begin
          if (b == CH_DOT) begin
            tok_byte(b);
            st = LX_FRAC_FIRST;
          end else close_token(TT_DEC, b);
        end
        LX_DEC: begin
          if (num_ch(b)) tok_byte(b);
          else if (b == CH_DOT) begin
            tok_byte(b);
            st = LX_FRAC_FIRST;
          end else close_token(TT_DEC, b);
        end
        LX_FRAC_FIRST, LX_FRAC: begin
          if (num_ch(b)) begin
            tok_byte(b);
            st = LX_FRAC;
          end else if (st == LX_FRAC_FIRST) tok_err(ERR_FRAC_DIGIT);
          else close_token(TT_DEC, b);
        end
        LX_SYMBOL: begin
          if (sym_ch(b)) begin
            tok_byte(b);
            lone_us = 1'b0;
          end else close_token(lone_us ? TT_US : TT_SYM, b);
        end
        default: begin
        end
      endcase
    endfunction

    // End of stream: close a complete token, flag an unfinished one
    function void finish_stream();
      case (st)
        LX_BIN: tok_end(TT_BIN);
        LX_HEX: tok_end(TT_HEX);
        LX_KEYWORD: tok_end(TT_KW);
        LX_ZERO, LX_DEC, LX_FRAC: tok_end(TT_DEC);
        LX_SYMBOL: tok_end(lone_us ? TT_US : TT_SYM);
        LX_HASH, LX_BIN_FIRST, LX_HEX_FIRST, LX_STRING, LX_ESCAPE, LX_QUOTED,
        LX_COLON, LX_FRAC_FIRST: tok_err(ERR_UNFINISHED);
        default: begin
        end
      endcase
      st = LX_IDLE;
      lone_us = 1'b0;
    endfunction

    // Predict the events of one accepted transaction; returns 0 if it is ignored
    function bit note_input(logic [7:0] b, logic eoi);
      bit ignored;
      lex_event_t x;
      ignored = (st == LX_HALT) && !eoi;
      step_res.delete();
      if (eoi) finish_stream();
      else lex_byte(b);
      foreach (step_res[i]) begin
        x.r = step_res[i];
        x.last = (i == step_res.size() - 1);
        pending_events = {pending_events, x};
      end
      return !ignored;
    endfunction

    function string show(logic [1:0] ev, logic [7:0] d, logic [3:0] t, logic [3:0] e,
                         logic last);
      return $sformatf("ev=%0d byte=%02h type=%0d err=%0d last=%0d", ev, d, t, e, last);
    endfunction

    function void check_result(logic [1:0] ev, logic [7:0] d, logic [3:0] t,
                               logic [3:0] e, logic last);
      lex_event_t x;
      if (pending_events.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected event: ev=%0d byte=%02h type=%0d err=%0d last=%0d",
                   ev, d, t, e, last);
        return;
      end
      x = pending_events.pop_front();
      if (ev !== x.r.ev || d !== x.r.dat || t !== x.r.ttype || e !== x.r.err ||
          last !== x.last) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected %s, got %s",
                   show(x.r.ev, x.r.dat, x.r.ttype, x.r.err, x.last),
                   show(ev, d, t, e, last));
      end
    endfunction

    function bit halted();
      return st == LX_HALT;
    endfunction

    function int outstanding();
      return pending_events.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = '0;
  logic       in_end_of_input = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_event_res;
  logic [7:0] out_byte;
  logic [3:0] out_token_type;
  logic [3:0] out_error_code;
  logic       out_last;

  lexer_scoreboard sb = new();
  bit calm = 1'b0;
  int counted = 0;

  smtlib2_token_lexer_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_end_of_input(in_end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_res(out_event_res),
    .out_byte(out_byte),
    .out_token_type(out_token_type),
    .out_error_code(out_error_code),
    .out_last(out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Check accepted results and stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_event_res, out_byte, out_token_type, out_error_code, out_last);
      out_stall <= !calm && ($urandom_range(99) < 15);
    end
  end

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Present one transaction after a random gap and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic eoi);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (sb.note_input(b, eoi)) counted++;
  endtask

  task automatic send_char(input logic [7:0] b);
    send_item(b, 1'b0);
  endtask

  task automatic send_eoi();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Hold the sender until every predicted event has arrived
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic directed_part();
    // illegal byte, ignored while halted, end of input while halted
    send_char(8'h00);
    send_char(8'hFF);
    send_eoi();
    // lone underscore closed by end of input
    send_char(CH_USCORE);
    send_eoi();
    // leading zero ends at a digit; decimal ends at a paren
    send_char(CH_ZERO);
    send_char(CH_ONE);
    send_char(CH_RPAR);
    // hex ended by a paren gives three events
    send_char(CH_HASH);
    send_char(CH_LOW_X);
    send_char("F");
    send_char(CH_LPAR);
    // string with an escaped quote
    send_char(CH_DQUOTE);
    send_char(CH_BSLASH);
    send_char(CH_DQUOTE);
    send_char(CH_DQUOTE);
    // quoted symbol
    send_char(CH_BAR);
    send_char("a");
    send_char(CH_BAR);
    // comment with a high byte
    send_char(CH_SEMI);
    send_char(8'h80);
    send_char(CH_LF);
    // unfinished keyword at end of input
    send_char(CH_COLON);
    send_eoi();
  endtask

  // Send one random token, mostly well formed
  task automatic gen_token();
    int kind;
    int n;
    logic [7:0] c;
    kind = $urandom_range(99);
    n = $urandom_range(1, 5);
    if (kind < 10) send_char($urandom_range(1) ? CH_LPAR : CH_RPAR);
    else if (kind < 18) begin
      send_char(CH_HASH);
      send_char(CH_LOW_B);
      repeat (n) send_char($urandom_range(1) ? CH_ONE : CH_ZERO);
    end else if (kind < 26) begin
      send_char(CH_HASH);
      send_char(CH_LOW_X);
      repeat (n) send_char(pick(HEX_DIGITS));
    end else if (kind < 38) begin
      if ($urandom_range(2) == 0) send_char(CH_ZERO);
      else begin
        send_char(pick("123456789"));
        repeat (n - 1) send_char(pick(DIGITS));
      end
      if ($urandom_range(1)) begin
        send_char(CH_DOT);
        repeat ($urandom_range(1, 3)) send_char(pick(DIGITS));
      end
    end else if (kind < 46) begin
      send_char(CH_DQUOTE);
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_DQUOTE || c == CH_BSLASH) begin
          send_char(CH_BSLASH);
          send_char($urandom_range(1) ? CH_DQUOTE : CH_BSLASH);
        end else if ($urandom_range(7) == 0) send_char($urandom_range(1) ? CH_TAB : CH_LF);
        else send_char(c);
      end
      send_char(CH_DQUOTE);
    end else if (kind < 52) begin
      send_char(CH_BAR);
      repeat ($urandom_range(0, 5)) begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == CH_BAR || c == CH_BSLASH) c = "q";
        send_char(c);
      end
      send_char(CH_BAR);
    end else if (kind < 60) begin
      send_char(CH_COLON);
      repeat (n) send_char(pick(SYM_CHARS));
    end else if (kind < 72) begin
      if ($urandom_range(3) == 0) send_char(CH_USCORE);
      else begin
        send_char(pick(SYM_START));
        repeat (n - 1) send_char(pick(SYM_CHARS));
      end
    end else if (kind < 80) begin
      case ($urandom_range(3))
        0: send_char(CH_SPACE);
        1: send_char(CH_TAB);
        2: send_char(CH_CR);
        default: send_char(CH_LF);
      endcase
    end else if (kind < 84) begin
      send_char(CH_SEMI);
      repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(255)));
      send_char(CH_LF);
    end else if (kind < 90) send_char(8'($urandom_range(255)));
    else if (kind < 96) begin
      // broken token: a prefix, then a random byte or end of input
      case ($urandom_range(7))
        0: send_char(CH_HASH);
        1: begin
          send_char(CH_HASH);
          send_char(CH_LOW_B);
        end
        2: begin
          send_char(CH_HASH);
          send_char(CH_LOW_X);
        end
        3: send_char(CH_COLON);
        4: send_char(CH_DQUOTE);
        5: begin
          send_char(CH_DQUOTE);
          send_char(CH_BSLASH);
        end
        6: send_char(CH_BAR);
        default: begin
          send_char(CH_ONE);
          send_char(CH_DOT);
        end
      endcase
      if ($urandom_range(3) == 0) send_eoi();
      else send_char(8'($urandom_range(255)));
    end else send_eoi();
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_part();
    while (counted < ITEM_GOAL) begin
      // recover from a lexical error with end of input, now and then after noise
      if (sb.halted()) begin
        if ($urandom_range(3) == 0) send_char(8'($urandom_range(255)));
        else send_eoi();
      end else gen_token();
      calm = (counted >= 120) && (counted < 200);
      if (!paused && counted >= 250) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
    if (sb.failures == 0 && sb.outstanding() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
